[rtl/pva_pkg.sv]
// Package of the polyphonic voice allocator with per-voice linear envelopes.
// Holds sizes, codes, command and status structs and the generator function.
// No dependencies.
`timescale 1ns / 1ps

package pva_pkg;

    localparam int NUM_VOICES = 8;
    localparam int MAX_REPORT = 8;
    localparam int NUM_REPORT = (NUM_VOICES < MAX_REPORT) ? NUM_VOICES : MAX_REPORT;
    localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CNT_W = $clog2(NUM_VOICES + 1);

    localparam int LEVEL_W = 24;
    localparam int AGE_W = 32;
    localparam int RNG_W = 32;
    localparam int DRAW_W = 23;
    localparam int NOTE_W = 7;
    localparam int VOUT_W = 3;
    localparam int COUT_W = 4;
    localparam int CIDX_W = 8;

    localparam logic [LEVEL_W-1:0] ONE_LEVEL = 24'h800000;
    localparam logic [RNG_W-1:0] RNG_SEED = 32'd123456789;
    localparam logic [RNG_W-1:0] RNG_STRIDE = 32'd987654;
    localparam int XS_A = 13;
    localparam int XS_B = 17;
    localparam int XS_C = 5;

    typedef logic [VIDX_W-1:0] t_vidx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [AGE_W-1:0] t_age;
    typedef logic [RNG_W-1:0] t_rng;
    typedef logic [DRAW_W-1:0] t_draw;
    typedef logic [NOTE_W-1:0] t_note;
    typedef logic [CIDX_W-1:0] t_cfg_idx;
    typedef logic [1:0] t_req;

    localparam t_req REQ_NOTE_ON = 2'd0;
    localparam t_req REQ_NOTE_OFF = 2'd1;
    localparam t_req REQ_TICK = 2'd2;

    localparam t_cfg_idx CFG_ATTACK = 8'd0;
    localparam t_cfg_idx CFG_DECAY = 8'd1;
    localparam t_cfg_idx CFG_SUSTAIN = 8'd2;
    localparam t_cfg_idx CFG_RELEASE = 8'd3;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } t_env_stage;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_ON,
        S_SCAN_OFF,
        S_SCAN_TICK,
        S_DRAW_TRIG,
        S_DRAW_LEFT,
        S_DRAW_RIGHT,
        S_EMIT_ON,
        S_EMIT_TICK
    } t_ctrl_state;

    typedef enum logic [1:0] {
        SCAN_NONE,
        SCAN_RELEASE,
        SCAN_TICK
    } t_scan_op;

    typedef enum logic [1:0] {
        DRAW_TRIG,
        DRAW_LEFT,
        DRAW_RIGHT
    } t_draw_sel;

    typedef struct packed {
        logic      start;
        t_scan_op  scan;
        logic      draw;
        t_draw_sel draw_sel;
        logic      alloc;
        logic      emit_on;
        logic      emit_tick;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic emit_last;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic [VOUT_W-1:0] voice_index;
        t_level            envelope;
        logic              voice_on;
        t_draw             trigger_rand;
        t_draw             phase_left;
        t_draw             phase_right;
        logic [COUT_W-1:0] active_count;
        logic              last;
    } t_result;

    function automatic t_rng xorshift32(input t_rng s);
        t_rng x;
        x = s;
        x = x ^ (x << XS_A);
        x = x ^ (x >> XS_B);
        x = x ^ (x << XS_C);
        return x;
    endfunction

    function automatic t_rng rng_seed(input int v);
        return RNG_SEED + RNG_W'(v) * RNG_STRIDE;
    endfunction

    function automatic logic [COUT_W-1:0] sat_count(input t_cnt c);
        return (32'(c) > 32'd15) ? 4'd15 : COUT_W'(c);
    endfunction

endpackage

[rtl/pva_req_if.sv]
// Request channel interface: request type and note number.
// Depends on pva_pkg.
`timescale 1ns / 1ps

interface pva_req_if;
    logic            valid;
    logic            ready;
    pva_pkg::t_req   req_type;
    pva_pkg::t_note  note;

    modport source (output valid, output req_type, output note, input ready);
    modport sink (input valid, input req_type, input note, output ready);
endinterface

[rtl/pva_res_if.sv]
// Result channel interface: one voice report per transaction.
// Depends on pva_pkg.
`timescale 1ns / 1ps

interface pva_res_if;
    logic                            valid;
    logic                            ready;
    logic [pva_pkg::VOUT_W-1:0]      voice_index;
    pva_pkg::t_level                 envelope;
    logic                            voice_on;
    pva_pkg::t_draw                  trigger_rand;
    pva_pkg::t_draw                  phase_left;
    pva_pkg::t_draw                  phase_right;
    logic [pva_pkg::COUT_W-1:0]      active_count;
    logic                            last;

    modport source (output valid, output voice_index, output envelope, output voice_on,
                    output trigger_rand, output phase_left, output phase_right,
                    output active_count, output last, input ready);
    modport sink (input valid, input voice_index, input envelope, input voice_on,
                  input trigger_rand, input phase_left, input phase_right,
                  input active_count, input last, output ready);
endinterface

[rtl/pva_cfg_if.sv]
// Configuration write channel interface: register index and write data.
// Depends on pva_pkg.
`timescale 1ns / 1ps

interface pva_cfg_if;
    logic               valid;
    logic               ready;
    pva_pkg::t_cfg_idx  index;
    pva_pkg::t_level    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/pva_ctrl.sv]
// Controller state machine of the voice allocator.
// Sequences scans, generator draws and result transactions; depends on pva_pkg.
`timescale 1ns / 1ps

module pva_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  pva_pkg::t_req     i_req_type,
    output logic              o_req_ready,
    input  pva_pkg::t_dp_stat i_stat,
    output pva_pkg::t_dp_cmd  o_cmd
);

    pva_pkg::t_ctrl_state r_state;
    pva_pkg::t_ctrl_state n_state;
    logic                 w_accept;

    assign w_accept = i_req_valid && (r_state == pva_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pva_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pva_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (i_req_type)
                        pva_pkg::REQ_NOTE_ON:  n_state = pva_pkg::S_SCAN_ON;
                        pva_pkg::REQ_NOTE_OFF: n_state = pva_pkg::S_SCAN_OFF;
                        pva_pkg::REQ_TICK:     n_state = pva_pkg::S_SCAN_TICK;
                        default:               n_state = pva_pkg::S_IDLE;
                    endcase
                end
            end
            pva_pkg::S_SCAN_ON: begin
                if (i_stat.scan_last) n_state = pva_pkg::S_DRAW_TRIG;
            end
            pva_pkg::S_SCAN_OFF: begin
                if (i_stat.scan_last) n_state = pva_pkg::S_IDLE;
            end
            pva_pkg::S_SCAN_TICK: begin
                if (i_stat.scan_last) n_state = pva_pkg::S_EMIT_TICK;
            end
            pva_pkg::S_DRAW_TRIG:  n_state = pva_pkg::S_DRAW_LEFT;
            pva_pkg::S_DRAW_LEFT:  n_state = pva_pkg::S_DRAW_RIGHT;
            pva_pkg::S_DRAW_RIGHT: n_state = pva_pkg::S_EMIT_ON;
            pva_pkg::S_EMIT_ON: begin
                if (i_stat.out_free) n_state = pva_pkg::S_IDLE;
            end
            pva_pkg::S_EMIT_TICK: begin
                if (i_stat.out_free && i_stat.emit_last) n_state = pva_pkg::S_IDLE;
            end
            default: n_state = pva_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready = (r_state == pva_pkg::S_IDLE);
        o_cmd = '0;
        o_cmd.scan = pva_pkg::SCAN_NONE;
        o_cmd.draw_sel = pva_pkg::DRAW_TRIG;
        case (r_state)
            pva_pkg::S_IDLE:      o_cmd.start = w_accept;
            pva_pkg::S_SCAN_ON:   o_cmd.scan = pva_pkg::SCAN_RELEASE;
            pva_pkg::S_SCAN_OFF:  o_cmd.scan = pva_pkg::SCAN_RELEASE;
            pva_pkg::S_SCAN_TICK: o_cmd.scan = pva_pkg::SCAN_TICK;
            pva_pkg::S_DRAW_TRIG: begin
                o_cmd.draw = 1'b1;
                o_cmd.alloc = 1'b1;
                o_cmd.draw_sel = pva_pkg::DRAW_TRIG;
            end
            pva_pkg::S_DRAW_LEFT: begin
                o_cmd.draw = 1'b1;
                o_cmd.draw_sel = pva_pkg::DRAW_LEFT;
            end
            pva_pkg::S_DRAW_RIGHT: begin
                o_cmd.draw = 1'b1;
                o_cmd.draw_sel = pva_pkg::DRAW_RIGHT;
            end
            pva_pkg::S_EMIT_ON:   o_cmd.emit_on = i_stat.out_free;
            pva_pkg::S_EMIT_TICK: o_cmd.emit_tick = i_stat.out_free;
            default: o_cmd.start = 1'b0;
        endcase
    end

    a_on_enters_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req_type == pva_pkg::REQ_NOTE_ON) |=> r_state == pva_pkg::S_SCAN_ON)
        else $error("note on did not start the voice scan");

    a_draws_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pva_pkg::S_DRAW_TRIG) |=> ##1 r_state == pva_pkg::S_DRAW_RIGHT)
        else $error("generator draws out of sequence");

    a_off_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pva_pkg::S_SCAN_OFF && i_stat.scan_last) |=> r_state == pva_pkg::S_IDLE)
        else $error("note off scan did not return to idle");

endmodule

[rtl/pva_datapath.sv]
// Datapath of the voice allocator: voice state, envelope step, allocation
// trackers, generators, configuration registers and the output register.
// Depends on pva_pkg; driven by pva_ctrl.
`timescale 1ns / 1ps

module pva_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pva_pkg::t_note     i_note,
    input  logic               i_cfg_valid,
    input  pva_pkg::t_cfg_idx  i_cfg_index,
    input  pva_pkg::t_level    i_cfg_data,
    input  pva_pkg::t_dp_cmd   i_cmd,
    output pva_pkg::t_dp_stat  o_stat,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output pva_pkg::t_result   o_res
);

    localparam int N = pva_pkg::NUM_VOICES;

    pva_pkg::t_level r_attack, r_decay, r_sustain, r_release;

    logic                 r_active [N];
    logic                 r_gate   [N];
    pva_pkg::t_note       r_vnote  [N];
    pva_pkg::t_age        r_age    [N];
    pva_pkg::t_env_stage  r_stage  [N];
    pva_pkg::t_level      r_level  [N];
    pva_pkg::t_rng        r_rng    [N];

    pva_pkg::t_vidx  r_idx;
    pva_pkg::t_note  r_note_in;
    pva_pkg::t_cnt   r_cnt;
    logic            r_free_found, r_rel_found;
    pva_pkg::t_vidx  r_free_idx, r_rel_idx, r_all_idx;
    pva_pkg::t_age   r_rel_age, r_all_age;
    pva_pkg::t_draw  r_trig, r_pl, r_pr;
    logic            r_out_valid;
    pva_pkg::t_result r_out;

    pva_pkg::t_level      w_sus;
    logic                 w_cur_active, w_cur_gate, w_match, w_gate_after;
    pva_pkg::t_age        w_cur_age, w_age_next;
    pva_pkg::t_env_stage  w_stage_next;
    pva_pkg::t_level      w_cur_level, w_level_next;
    logic                 w_active_next;
    logic [pva_pkg::LEVEL_W:0] w_sum;
    pva_pkg::t_vidx       w_sel;
    pva_pkg::t_rng        w_draw;
    logic                 w_cnt_add;

    assign w_sus = (r_sustain > pva_pkg::ONE_LEVEL) ? pva_pkg::ONE_LEVEL : r_sustain;
    assign w_cur_active = r_active[r_idx];
    assign w_cur_gate = r_gate[r_idx];
    assign w_cur_age = r_age[r_idx];
    assign w_cur_level = r_level[r_idx];
    assign w_match = w_cur_active && (r_vnote[r_idx] == r_note_in);
    assign w_gate_after = w_cur_gate && !w_match;
    assign w_sel = r_free_found ? r_free_idx : (r_rel_found ? r_rel_idx : r_all_idx);
    assign w_draw = pva_pkg::xorshift32(r_rng[w_sel]);

    always_comb begin
        w_level_next = w_cur_level;
        w_stage_next = r_stage[r_idx];
        w_active_next = w_cur_active;
        w_age_next = w_cur_age;
        w_sum = '0;
        if (!w_cur_active) begin
            w_level_next = '0;
            w_stage_next = pva_pkg::ST_IDLE;
        end else begin
            if (w_cur_age != '1) w_age_next = w_cur_age + 1'b1;
            case (r_stage[r_idx])
                pva_pkg::ST_ATTACK: begin
                    w_sum = {1'b0, w_cur_level} + {1'b0, r_attack};
                    if (w_sum >= {1'b0, pva_pkg::ONE_LEVEL}) begin
                        w_level_next = pva_pkg::ONE_LEVEL;
                        w_stage_next = pva_pkg::ST_DECAY;
                    end else begin
                        w_level_next = w_sum[pva_pkg::LEVEL_W-1:0];
                    end
                end
                pva_pkg::ST_DECAY: begin
                    w_sum = {1'b0, r_decay} + {1'b0, w_sus};
                    if ({1'b0, w_cur_level} <= w_sum) begin
                        w_level_next = w_sus;
                        w_stage_next = pva_pkg::ST_SUSTAIN;
                    end else begin
                        w_level_next = w_cur_level - r_decay;
                    end
                end
                pva_pkg::ST_SUSTAIN: begin
                    w_level_next = w_sus;
                    if (!w_cur_gate) w_stage_next = pva_pkg::ST_RELEASE;
                end
                pva_pkg::ST_RELEASE: begin
                    if (w_cur_level <= r_release) begin
                        w_level_next = '0;
                        w_active_next = 1'b0;
                        w_stage_next = pva_pkg::ST_IDLE;
                    end else begin
                        w_level_next = w_cur_level - r_release;
                    end
                end
                default: begin
                    w_level_next = '0;
                    w_active_next = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        case (i_cmd.scan)
            pva_pkg::SCAN_TICK:    w_cnt_add = w_active_next;
            pva_pkg::SCAN_RELEASE: w_cnt_add = w_cur_active;
            default:               w_cnt_add = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack <= 24'd190217;
            r_decay <= '0;
            r_sustain <= pva_pkg::ONE_LEVEL;
            r_release <= 24'd190217;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pva_pkg::CFG_ATTACK:  r_attack <= i_cfg_data;
                pva_pkg::CFG_DECAY:   r_decay <= i_cfg_data;
                pva_pkg::CFG_SUSTAIN: r_sustain <= i_cfg_data;
                pva_pkg::CFG_RELEASE: r_release <= i_cfg_data;
                default: r_attack <= r_attack;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < N; v++) begin
                r_active[v] <= 1'b0;
                r_gate[v] <= 1'b0;
                r_vnote[v] <= '0;
                r_age[v] <= '0;
                r_stage[v] <= pva_pkg::ST_IDLE;
                r_level[v] <= '0;
                r_rng[v] <= pva_pkg::rng_seed(v);
            end
        end else begin
            case (i_cmd.scan)
                pva_pkg::SCAN_RELEASE: begin
                    if (w_match) begin
                        r_gate[r_idx] <= 1'b0;
                        r_stage[r_idx] <= pva_pkg::ST_RELEASE;
                    end
                end
                pva_pkg::SCAN_TICK: begin
                    r_active[r_idx] <= w_active_next;
                    r_age[r_idx] <= w_age_next;
                    r_stage[r_idx] <= w_stage_next;
                    r_level[r_idx] <= w_level_next;
                end
                default: ;
            endcase
            if (i_cmd.alloc) begin
                r_vnote[w_sel] <= r_note_in;
                r_gate[w_sel] <= 1'b1;
                r_age[w_sel] <= '0;
                r_active[w_sel] <= 1'b1;
                r_stage[w_sel] <= pva_pkg::ST_ATTACK;
                r_level[w_sel] <= '0;
            end
            if (i_cmd.draw) begin
                r_rng[w_sel] <= w_draw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_cnt <= '0;
            r_free_found <= 1'b0;
            r_rel_found <= 1'b0;
        end else if (i_cmd.start) begin
            r_idx <= '0;
            r_cnt <= '0;
            r_free_found <= 1'b0;
            r_rel_found <= 1'b0;
            r_all_idx <= '0;
            r_all_age <= '0;
        end else if (i_cmd.scan != pva_pkg::SCAN_NONE) begin
            r_idx <= o_stat.scan_last ? '0 : r_idx + 1'b1;
            r_cnt <= r_cnt + pva_pkg::CNT_W'(w_cnt_add);
            if (!r_free_found && !w_cur_active) begin
                r_free_found <= 1'b1;
                r_free_idx <= r_idx;
            end
            if (!w_gate_after && (!r_rel_found || w_cur_age > r_rel_age)) begin
                r_rel_found <= 1'b1;
                r_rel_idx <= r_idx;
                r_rel_age <= w_cur_age;
            end
            if (w_cur_age > r_all_age) begin
                r_all_idx <= r_idx;
                r_all_age <= w_cur_age;
            end
        end else if (i_cmd.alloc) begin
            r_cnt <= r_cnt + pva_pkg::CNT_W'(r_free_found);
        end else if (i_cmd.emit_tick) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_note_in <= i_note;
        end
        if (i_cmd.draw) begin
            case (i_cmd.draw_sel)
                pva_pkg::DRAW_TRIG:  r_trig <= w_draw[pva_pkg::DRAW_W-1:0];
                pva_pkg::DRAW_LEFT:  r_pl <= w_draw[pva_pkg::DRAW_W-1:0];
                pva_pkg::DRAW_RIGHT: r_pr <= w_draw[pva_pkg::DRAW_W-1:0];
                default:             r_trig <= r_trig;
            endcase
        end
        if (i_cmd.emit_on) begin
            r_out.voice_index <= pva_pkg::VOUT_W'(w_sel);
            r_out.envelope <= '0;
            r_out.voice_on <= 1'b1;
            r_out.trigger_rand <= r_trig;
            r_out.phase_left <= r_pl;
            r_out.phase_right <= r_pr;
            r_out.active_count <= pva_pkg::sat_count(r_cnt);
            r_out.last <= 1'b1;
        end else if (i_cmd.emit_tick) begin
            r_out.voice_index <= pva_pkg::VOUT_W'(r_idx);
            r_out.envelope <= w_cur_level;
            r_out.voice_on <= w_cur_active;
            r_out.trigger_rand <= '0;
            r_out.phase_left <= '0;
            r_out.phase_right <= '0;
            r_out.active_count <= pva_pkg::sat_count(r_cnt);
            r_out.last <= o_stat.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_on || i_cmd.emit_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.scan_last = (r_idx == pva_pkg::VIDX_W'(N - 1));
    assign o_stat.emit_last = (r_idx == pva_pkg::VIDX_W'(pva_pkg::NUM_REPORT - 1));
    assign o_stat.out_free = !r_out_valid || i_res_ready;
    assign o_res_valid = r_out_valid;
    assign o_res = r_out;

    a_rng_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.draw |-> (r_rng[w_sel] != '0))
        else $error("voice generator reached the all-zero state");

    a_start_clears_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> (r_idx == '0 && r_cnt == '0))
        else $error("scan index or count not cleared at start");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cnt) <= N))
        else $error("active voice count exceeds the number of voices");

endmodule

[rtl/poly_voice_allocator_adsr_core.sv]
// Top level of the polyphonic voice allocator with linear ADSR envelopes.
// Depends on pva_pkg, the three channel interfaces, pva_ctrl and pva_datapath.
//
//   Channel   Direction  Payload                                  Transaction
//   i_req     in         req_type, note                           valid & ready
//   o_res     out        voice_index .. last (one voice report)   valid & ready
//   i_cfg     in         index, data (register write)             valid & ready
//
// Each request is handled alone; the voices are scanned one per cycle.
// A note off scans the voices, a note on scans them, makes three generator draws
// and issues one result, and a tick scans them and then issues one result per
// reported voice (up to eight).
// A stalled result holds the block in its report phase; the output register
// lets the last result wait while the next request is accepted.
// Reset is synchronous and active low; configuration writes are always taken.
`timescale 1ns / 1ps

module poly_voice_allocator_adsr_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pva_req_if.sink    i_req,
    pva_res_if.source  o_res,
    pva_cfg_if.sink    i_cfg
);

    pva_pkg::t_dp_cmd  w_cmd;
    pva_pkg::t_dp_stat w_stat;
    pva_pkg::t_result  w_res;
    logic              w_req_ready;
    logic              w_res_valid;

    pva_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_req_ready (w_req_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pva_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_note      (i_req.note),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_res_valid (w_res_valid),
        .i_res_ready (o_res.ready),
        .o_res       (w_res)
    );

    assign i_req.ready = w_req_ready;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid = w_res_valid;
    assign o_res.voice_index = w_res.voice_index;
    assign o_res.envelope = w_res.envelope;
    assign o_res.voice_on = w_res.voice_on;
    assign o_res.trigger_rand = w_res.trigger_rand;
    assign o_res.phase_left = w_res.phase_left;
    assign o_res.phase_right = w_res.phase_right;
    assign o_res.active_count = w_res.active_count;
    assign o_res.last = w_res.last;

endmodule

[bench/tb_poly_voice_allocator_adsr_core.sv]
// Self-checking testbench for poly_voice_allocator_adsr_core: a directed table, then random
// note-on, note-off, tick and unused-code traffic under several register settings, checked per voice report.
// Depends on pva_pkg, the three channel interfaces and the RTL of the block.
`timescale 1ns / 1ps

module tb_poly_voice_allocator_adsr_core;

    import pva_pkg::*;

    localparam t_req       REQ_UNUSED       = 2'd3;
    localparam t_cfg_idx   CFG_FIRST_UNUSED = 8'd4;
    localparam t_cfg_idx   CFG_LAST_UNUSED  = 8'hFF;
    localparam int         N_PHASES         = 7;
    localparam int         ITEMS_PER_PHASE  = 40;
    localparam int         SETTLE_CYCLES    = 24;
    localparam int         LIMIT_NS         = 3_000_000;

    typedef enum {
        RX_ALWAYS,
        RX_RANDOM,
        RX_RUNS,
        RX_SPARSE
    } t_rx_pattern;

    typedef struct packed {
        t_req              req;
        t_note             note;
        logic              pinned;
        logic [VOUT_W-1:0] voice;
        logic [COUT_W-1:0] count;
    } t_stim_row;

    localparam t_stim_row DIRECTED_ROWS [22] = '{
        '{REQ_TICK,     7'd0,   1'b1, 3'd0, 4'd0},
        '{REQ_UNUSED,   7'd127, 1'b0, 3'd0, 4'd0},
        '{REQ_NOTE_ON,  7'd0,   1'b1, 3'd0, 4'd1},
        '{REQ_NOTE_ON,  7'd127, 1'b1, 3'd1, 4'd2},
        '{REQ_NOTE_ON,  7'd0,   1'b1, 3'd2, 4'd3},
        '{REQ_NOTE_OFF, 7'd127, 1'b0, 3'd0, 4'd0},
        '{REQ_TICK,     7'd0,   1'b1, 3'd0, 4'd1},
        '{REQ_NOTE_ON,  7'd85,  1'b1, 3'd0, 4'd2},
        '{REQ_NOTE_ON,  7'd42,  1'b1, 3'd1, 4'd3},
        '{REQ_NOTE_ON,  7'd10,  1'b1, 3'd3, 4'd4},
        '{REQ_NOTE_ON,  7'd11,  1'b1, 3'd4, 4'd5},
        '{REQ_NOTE_ON,  7'd12,  1'b1, 3'd5, 4'd6},
        '{REQ_NOTE_ON,  7'd13,  1'b1, 3'd6, 4'd7},
        '{REQ_NOTE_ON,  7'd14,  1'b1, 3'd7, 4'd8},
        '{REQ_NOTE_ON,  7'd0,   1'b1, 3'd2, 4'd8},
        '{REQ_TICK,     7'd0,   1'b0, 3'd0, 4'd0},
        '{REQ_NOTE_ON,  7'd60,  1'b1, 3'd0, 4'd8},
        '{REQ_NOTE_OFF, 7'd42,  1'b0, 3'd0, 4'd0},
        '{REQ_NOTE_ON,  7'd61,  1'b1, 3'd1, 4'd8},
        '{REQ_NOTE_OFF, 7'd127, 1'b0, 3'd0, 4'd0},
        '{REQ_TICK,     7'd0,   1'b0, 3'd0, 4'd0},
        '{REQ_TICK,     7'd0,   1'b0, 3'd0, 4'd0}
    };

    logic i_clk;
    logic i_rst_n;

    pva_req_if req_if ();
    pva_res_if res_if ();
    pva_cfg_if cfg_if ();

    poly_voice_allocator_adsr_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    logic       vc_active [NUM_VOICES];
    logic       vc_gate   [NUM_VOICES];
    t_note      vc_note   [NUM_VOICES];
    t_age       vc_age    [NUM_VOICES];
    t_env_stage vc_stage  [NUM_VOICES];
    t_level     vc_level  [NUM_VOICES];
    t_rng       vc_rng    [NUM_VOICES];

    t_level reg_attack;
    t_level reg_decay;
    t_level reg_sustain;
    t_level reg_release;

    t_result     pending_reports [$];
    t_result     fresh_reports   [$];
    int          mismatches;
    int          burst_left;
    bit          steady;
    t_rx_pattern rx_mode;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("** poly_voice_allocator_adsr_core: FAILED **");
        $finish;
    end

    function automatic t_draw next_draw(input int v);
        t_rng x;
        x = vc_rng[v];
        x = x ^ (x << XS_A);
        x = x ^ (x >> XS_B);
        x = x ^ (x << XS_C);
        vc_rng[v] = x;
        return t_draw'(x);
    endfunction

    function automatic logic [COUT_W-1:0] sounding_voices();
        int n;
        n = 0;
        foreach (vc_active[v]) n += vc_active[v];
        return (n > 15) ? 4'd15 : COUT_W'(n);
    endfunction

    task automatic release_matching(input t_note note);
        foreach (vc_active[v]) begin
            if (vc_active[v] && vc_note[v] == note) begin
                vc_gate[v] = 1'b0;
                vc_stage[v] = ST_RELEASE;
            end
        end
    endtask

    task automatic advance_voices(input t_req req, input t_note note);
        int      chosen;
        longint  sum;
        t_level  sus;
        t_result r;
        fresh_reports.delete();
        case (req)
            REQ_NOTE_ON: begin
                release_matching(note);
                chosen = -1;
                for (int v = 0; v < NUM_VOICES && chosen < 0; v++) begin
                    if (!vc_active[v]) chosen = v;
                end
                if (chosen < 0) begin
                    for (int v = 0; v < NUM_VOICES; v++) begin
                        if (!vc_gate[v] && (chosen < 0 || vc_age[v] > vc_age[chosen])) chosen = v;
                    end
                end
                if (chosen < 0) begin
                    chosen = 0;
                    for (int v = 1; v < NUM_VOICES; v++) begin
                        if (vc_age[v] > vc_age[chosen]) chosen = v;
                    end
                end
                vc_note[chosen] = note;
                vc_gate[chosen] = 1'b1;
                vc_age[chosen] = '0;
                vc_active[chosen] = 1'b1;
                vc_stage[chosen] = ST_ATTACK;
                vc_level[chosen] = '0;
                r.voice_index = VOUT_W'(chosen);
                r.envelope = '0;
                r.voice_on = 1'b1;
                r.trigger_rand = next_draw(chosen);
                r.phase_left = next_draw(chosen);
                r.phase_right = next_draw(chosen);
                r.active_count = sounding_voices();
                r.last = 1'b1;
                fresh_reports.push_back(r);
            end
            REQ_NOTE_OFF: begin
                release_matching(note);
            end
            REQ_TICK: begin
                sus = (reg_sustain > ONE_LEVEL) ? ONE_LEVEL : reg_sustain;
                for (int v = 0; v < NUM_VOICES; v++) begin
                    if (!vc_active[v]) begin
                        vc_level[v] = '0;
                        vc_stage[v] = ST_IDLE;
                    end else begin
                        if (vc_age[v] != '1) vc_age[v] = vc_age[v] + 1;
                        case (vc_stage[v])
                            ST_ATTACK: begin
                                sum = longint'(vc_level[v]) + longint'(reg_attack);
                                if (sum >= longint'(ONE_LEVEL)) begin
                                    vc_level[v] = ONE_LEVEL;
                                    vc_stage[v] = ST_DECAY;
                                end else begin
                                    vc_level[v] = t_level'(sum);
                                end
                            end
                            ST_DECAY: begin
                                sum = longint'(vc_level[v]) - longint'(reg_decay);
                                if (sum <= longint'(sus)) begin
                                    vc_level[v] = sus;
                                    vc_stage[v] = ST_SUSTAIN;
                                end else begin
                                    vc_level[v] = t_level'(sum);
                                end
                            end
                            ST_SUSTAIN: begin
                                vc_level[v] = sus;
                                if (!vc_gate[v]) vc_stage[v] = ST_RELEASE;
                            end
                            ST_RELEASE: begin
                                sum = longint'(vc_level[v]) - longint'(reg_release);
                                if (sum <= 0) begin
                                    vc_level[v] = '0;
                                    vc_active[v] = 1'b0;
                                    vc_stage[v] = ST_IDLE;
                                end else begin
                                    vc_level[v] = t_level'(sum);
                                end
                            end
                            default: begin
                                vc_level[v] = '0;
                                vc_active[v] = 1'b0;
                            end
                        endcase
                    end
                end
                for (int k = 0; k < NUM_REPORT; k++) begin
                    r.voice_index = VOUT_W'(k);
                    r.envelope = vc_level[k];
                    r.voice_on = vc_active[k];
                    r.trigger_rand = '0;
                    r.phase_left = '0;
                    r.phase_right = '0;
                    r.active_count = sounding_voices();
                    r.last = (k == NUM_REPORT - 1);
                    fresh_reports.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    task automatic offer_request(input t_req req, input t_note note, input logic pinned,
                                 input logic [VOUT_W-1:0] pin_voice,
                                 input logic [COUT_W-1:0] pin_count);
        req_if.valid = 1'b1;
        req_if.req_type = req;
        req_if.note = note;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        advance_voices(req, note);
        foreach (fresh_reports[k]) begin
            if (pinned) begin
                if (req == REQ_NOTE_ON) fresh_reports[k].voice_index = pin_voice;
                fresh_reports[k].active_count = pin_count;
            end
            pending_reports.push_back(fresh_reports[k]);
        end
        @(negedge i_clk);
    endtask

    task automatic pace_sender();
        if (!steady) begin
            burst_left--;
            if (burst_left <= 0) begin
                req_if.valid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    task automatic drain_reports(input int settle);
        req_if.valid = 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_level value);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data = value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_ATTACK:  reg_attack = value;
            CFG_DECAY:   reg_decay = value;
            CFG_SUSTAIN: reg_sustain = value;
            CFG_RELEASE: reg_release = value;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: voice report expected none, got voice_index 0x%0h", $time,
                         res_if.voice_index);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                compare_field("voice_index", want.voice_index, res_if.voice_index);
                compare_field("envelope", want.envelope, res_if.envelope);
                compare_field("voice_on", want.voice_on, res_if.voice_on);
                compare_field("trigger_rand", want.trigger_rand, res_if.trigger_rand);
                compare_field("phase_left", want.phase_left, res_if.phase_left);
                compare_field("phase_right", want.phase_right, res_if.phase_right);
                compare_field("active_count", want.active_count, res_if.active_count);
                compare_field("last", want.last, res_if.last);
            end
        end
    end

    initial begin
        int  run_left;
        int  sparse_count;
        bit  stall_now;
        res_if.ready = 1'b0;
        run_left = 0;
        sparse_count = 0;
        stall_now = 1'b0;
        forever begin
            @(negedge i_clk);
            case (rx_mode)
                RX_ALWAYS: res_if.ready = 1'b1;
                RX_RANDOM: res_if.ready = ($urandom_range(0, 3) != 0);
                RX_RUNS: begin
                    if (run_left == 0) begin
                        stall_now = !stall_now;
                        run_left = $urandom_range(1, 10);
                    end
                    run_left--;
                    res_if.ready = !stall_now;
                end
                default: begin
                    sparse_count = (sparse_count + 1) % 4;
                    res_if.ready = (sparse_count == 0);
                end
            endcase
        end
    end

    initial begin
        int    done;
        int    pick;
        int    pool_base;
        t_req  req;
        t_note note;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_TICK;
        req_if.note = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_ATTACK;
        cfg_if.data = '0;
        mismatches = 0;
        burst_left = 0;
        steady = 1'b0;
        rx_mode = RX_RANDOM;
        reg_attack = 24'd190217;
        reg_decay = '0;
        reg_sustain = ONE_LEVEL;
        reg_release = 24'd190217;
        for (int v = 0; v < NUM_VOICES; v++) begin
            vc_active[v] = 1'b0;
            vc_gate[v] = 1'b0;
            vc_note[v] = '0;
            vc_age[v] = '0;
            vc_stage[v] = ST_IDLE;
            vc_level[v] = '0;
            vc_rng[v] = RNG_SEED + t_rng'(v) * RNG_STRIDE;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED_ROWS[k]) begin
            offer_request(DIRECTED_ROWS[k].req, DIRECTED_ROWS[k].note, DIRECTED_ROWS[k].pinned,
                          DIRECTED_ROWS[k].voice, DIRECTED_ROWS[k].count);
            pace_sender();
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            drain_reports(SETTLE_CYCLES);
            case (phase)
                1: begin
                    write_reg(CFG_ATTACK, ONE_LEVEL);
                    write_reg(CFG_DECAY, 24'h100000);
                    write_reg(CFG_SUSTAIN, 24'h400000);
                    write_reg(CFG_RELEASE, 24'h080000);
                end
                2: begin
                    write_reg(CFG_ATTACK, 24'hFFFFFF);
                    write_reg(CFG_DECAY, 24'hFFFFFF);
                    write_reg(CFG_SUSTAIN, 24'hFFFFFF);
                    write_reg(CFG_RELEASE, 24'hFFFFFF);
                end
                3: begin
                    write_reg(CFG_ATTACK, '0);
                    write_reg(CFG_DECAY, '0);
                    write_reg(CFG_SUSTAIN, '0);
                    write_reg(CFG_RELEASE, '0);
                end
                4: begin
                    write_reg(CFG_ATTACK, 24'h2AAAAA);
                    write_reg(CFG_DECAY, '0);
                    write_reg(CFG_SUSTAIN, 24'h7FFFFF);
                    write_reg(CFG_RELEASE, '0);
                    write_reg(CFG_FIRST_UNUSED, 24'h555555);
                    write_reg(CFG_LAST_UNUSED, 24'hABCDEF);
                end
                5: begin
                    write_reg(CFG_ATTACK, t_level'($urandom_range(1, ONE_LEVEL)));
                    write_reg(CFG_DECAY, t_level'($urandom_range(0, 24'h100000)));
                    write_reg(CFG_SUSTAIN, t_level'($urandom_range(0, ONE_LEVEL)));
                    write_reg(CFG_RELEASE, t_level'($urandom_range(0, 24'h100000)));
                end
                6: begin
                    write_reg(CFG_ATTACK, 24'd1);
                    write_reg(CFG_DECAY, ONE_LEVEL);
                    write_reg(CFG_SUSTAIN, '0);
                    write_reg(CFG_RELEASE, ONE_LEVEL);
                end
                default: ;
            endcase
            rx_mode = t_rx_pattern'(phase % 4);
            steady = (phase == 4);
            pool_base = $urandom_range(0, 122);
            done = 0;
            while (done < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) req = REQ_NOTE_ON;
                else if (pick < 60) req = REQ_NOTE_OFF;
                else if (pick < 95) req = REQ_TICK;
                else req = REQ_UNUSED;
                if ($urandom_range(0, 9) < 7) note = t_note'(pool_base + $urandom_range(0, 5));
                else note = t_note'($urandom_range(0, 127));
                offer_request(req, note, 1'b0, '0, '0);
                if (req != REQ_UNUSED) done++;
                if (done == ITEMS_PER_PHASE / 2 && phase % 2 == 1) drain_reports(0);
                pace_sender();
            end
        end

        drain_reports(SETTLE_CYCLES);
        if (mismatches == 0) begin
            $display("** poly_voice_allocator_adsr_core: PASSED **");
        end else begin
            $display("** poly_voice_allocator_adsr_core: FAILED **");
        end
        $finish;
    end

endmodule
